FILE: src/ultrasonic_echo_ranger_assert.svh
// Assertion macros for the ultrasonic echo ranger.
// Depends on nothing; included by the top level only.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// Check cons in the same cycle whenever ante holds.
`define UER_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uer assertion failed");

// Check cons in the cycle after ante holds.
`define UER_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uer assertion failed");

`endif

FILE: src/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// Depends on nothing; used by every module of the block.
package uer_pkg;

   localparam int TICK_W      = 17;
   localparam int DIST_W      = 17;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 3;
   localparam int MUL_W       = 15;
   localparam int PROD_W      = TICK_W + MUL_W;
   localparam int DIST_SHIFT  = 14;

   localparam logic [MUL_W-1:0]  DIST_MUL = MUL_W'(28099);
   localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(131071);

   // Register reset values
   localparam logic [7:0]  SETTLE_RST  = 8'd2;
   localparam logic [7:0]  TRIGGER_RST = 8'd10;
   localparam logic [15:0] TIMEOUT_RST = 16'd30000;
   localparam logic [16:0] MID_RST     = 17'd1500;
   localparam logic [16:0] FAR_RST     = 17'd2500;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SETTLE  = 3'd0,
      CSR_TRIGGER = 3'd1,
      CSR_TIMEOUT = 3'd2,
      CSR_MID     = 3'd3,
      CSR_FAR     = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_SETTLE = 3'd1,
      PH_TRIG   = 3'd2,
      PH_RISE   = 3'd3,
      PH_HIGH   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_ECHO    = 2'd1,
      ST_ECHO_STUCK = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0]        settle_ticks;
      logic [7:0]        trigger_ticks;
      logic [15:0]       timeout_ticks;
      logic [DIST_W-1:0] mid_threshold;
      logic [DIST_W-1:0] far_threshold;
   } cfg_type;

   // Per-beat outcome of the phase machine
   typedef struct packed {
      logic              trigger;
      logic              busy;
      logic              done;
      logic              good;
      status_type        status;
      logic [TICK_W-1:0] ticks;
   } evt_type;

   // Lamp bits: far, mid, near
   typedef struct packed {
      logic far_on;
      logic mid_on;
      logic near_on;
   } lamp_type;

endpackage

FILE: src/uer_if.sv
// Valid/ready channel interfaces for the ultrasonic echo ranger.
// Depends on uer_pkg for field widths.
interface uer_req_if;
   logic valid;
   logic ready;
   logic start_req;
   logic echo_level;

   modport source (output valid, output start_req, output echo_level, input ready);
   modport sink (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      trigger_level;
   logic                      busy_res;
   logic                      done_res;
   logic [1:0]                status;
   logic [uer_pkg::DIST_W-1:0] distance;
   logic                      lamp_far;
   logic                      lamp_mid;
   logic                      lamp_near;

   modport source (output valid, output trigger_level, output busy_res, output done_res,
                   output status, output distance, output lamp_far, output lamp_mid,
                   output lamp_near, input ready);
   modport sink (input valid, input trigger_level, input busy_res, input done_res,
                 input status, input distance, input lamp_far, input lamp_mid,
                 input lamp_near, output ready);
endinterface

FILE: src/uer_csr.sv
// Configuration register file for the ultrasonic echo ranger.
// Depends on uer_pkg for register indexes, reset values and cfg_type.
module uer_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [uer_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [uer_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output uer_pkg::cfg_type                 cfg
);

   uer_pkg::cfg_type cfg_ff;
   uer_pkg::cfg_type cfg_in;

   // Write one register; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            uer_pkg::CSR_SETTLE:  cfg_in.settle_ticks  = csr_wdata[7:0];
            uer_pkg::CSR_TRIGGER: cfg_in.trigger_ticks = csr_wdata[7:0];
            uer_pkg::CSR_TIMEOUT: cfg_in.timeout_ticks = csr_wdata[15:0];
            uer_pkg::CSR_MID:     cfg_in.mid_threshold = csr_wdata[uer_pkg::DIST_W-1:0];
            uer_pkg::CSR_FAR:     cfg_in.far_threshold = csr_wdata[uer_pkg::DIST_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ticks  <= uer_pkg::SETTLE_RST;
         cfg_ff.trigger_ticks <= uer_pkg::TRIGGER_RST;
         cfg_ff.timeout_ticks <= uer_pkg::TIMEOUT_RST;
         cfg_ff.mid_threshold <= uer_pkg::MID_RST;
         cfg_ff.far_threshold <= uer_pkg::FAR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/uer_ctrl.sv
// Phase machine and tick counter of the ultrasonic echo ranger.
// Depends on uer_pkg for phase_type, status_type, cfg_type and evt_type.
module uer_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             start_req,
   input  logic             echo_level,
   input  uer_pkg::cfg_type cfg,
   output uer_pkg::evt_type evt
);

   uer_pkg::phase_type              phase_ff, phase_in;
   logic [uer_pkg::TICK_W-1:0]      tick_ff, tick_in;
   logic [uer_pkg::TICK_W-1:0]      tick_inc;
   logic                            over_limit;
   logic                            done;
   logic                            good;
   uer_pkg::status_type             status;

   assign tick_inc   = tick_ff + uer_pkg::TICK_W'(1);
   assign over_limit = tick_inc > uer_pkg::TICK_W'(cfg.timeout_ticks);

   // Next phase and count for one tick
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      done     = 1'b0;
      good     = 1'b0;
      status   = uer_pkg::ST_OK;
      unique case (phase_ff)
         uer_pkg::PH_IDLE: begin
            if (start_req) begin
               phase_in = (cfg.settle_ticks != 8'd0) ? uer_pkg::PH_SETTLE : uer_pkg::PH_TRIG;
               tick_in  = uer_pkg::TICK_W'(1);
            end
         end
         uer_pkg::PH_SETTLE: begin
            if (tick_ff >= uer_pkg::TICK_W'(cfg.settle_ticks)) begin
               phase_in = uer_pkg::PH_TRIG;
               tick_in  = uer_pkg::TICK_W'(1);
            end else begin
               tick_in = tick_inc;
            end
         end
         uer_pkg::PH_TRIG: begin
            if (tick_ff >= uer_pkg::TICK_W'(cfg.trigger_ticks)) begin
               phase_in = uer_pkg::PH_RISE;
               tick_in  = '0;
            end else begin
               tick_in = tick_inc;
            end
         end
         uer_pkg::PH_RISE: begin
            if (echo_level) begin
               phase_in = uer_pkg::PH_HIGH;
               tick_in  = uer_pkg::TICK_W'(1);
            end else if (over_limit) begin
               phase_in = uer_pkg::PH_IDLE;
               tick_in  = '0;
               done     = 1'b1;
               status   = uer_pkg::ST_NO_ECHO;
            end else begin
               tick_in = tick_inc;
            end
         end
         uer_pkg::PH_HIGH: begin
            if (!echo_level) begin
               phase_in = uer_pkg::PH_IDLE;
               tick_in  = '0;
               done     = 1'b1;
               good     = 1'b1;
            end else if (over_limit) begin
               phase_in = uer_pkg::PH_IDLE;
               tick_in  = '0;
               done     = 1'b1;
               status   = uer_pkg::ST_ECHO_STUCK;
            end else begin
               tick_in = tick_inc;
            end
         end
         default: begin
            phase_in = uer_pkg::PH_IDLE;
            tick_in  = '0;
         end
      endcase
   end

   // Advance only on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= uer_pkg::PH_IDLE;
         tick_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
      end
   end

   assign evt.trigger = phase_in == uer_pkg::PH_TRIG;
   assign evt.busy    = phase_in != uer_pkg::PH_IDLE;
   assign evt.done    = done;
   assign evt.good    = good;
   assign evt.status  = status;
   assign evt.ticks   = tick_ff;

endmodule

FILE: src/uer_range.sv
// Distance conversion, band classification and held lamps.
// Depends on uer_pkg for widths, constants, cfg_type, evt_type and lamp_type.
module uer_range (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  uer_pkg::evt_type             evt,
   input  uer_pkg::cfg_type             cfg,
   output logic [uer_pkg::DIST_W-1:0]   distance_in,
   output uer_pkg::lamp_type            lamp_in
);

   logic [uer_pkg::PROD_W-1:0]             product;
   logic [uer_pkg::PROD_W-uer_pkg::DIST_SHIFT-1:0] scaled;
   logic [uer_pkg::DIST_W-1:0]             dist_new;
   uer_pkg::lamp_type                      lamp_new;
   logic [uer_pkg::DIST_W-1:0]             distance_ff;
   uer_pkg::lamp_type                      lamp_ff;
   logic                                   update;

   // Scale ticks to hundredths of a centimetre and saturate
   assign product  = uer_pkg::PROD_W'(evt.ticks) * uer_pkg::PROD_W'(uer_pkg::DIST_MUL);
   assign scaled   = product[uer_pkg::PROD_W-1:uer_pkg::DIST_SHIFT];
   assign dist_new = (scaled > (uer_pkg::PROD_W-uer_pkg::DIST_SHIFT)'(uer_pkg::DIST_MAX))
                     ? uer_pkg::DIST_MAX : scaled[uer_pkg::DIST_W-1:0];

   // Far test first, then mid
   always_comb begin
      lamp_new = '0;
      priority if (dist_new >= cfg.far_threshold) begin
         lamp_new.far_on = 1'b1;
      end else if (dist_new >= cfg.mid_threshold) begin
         lamp_new.mid_on = 1'b1;
      end else begin
         lamp_new.near_on = 1'b1;
      end
   end

   assign update      = step && evt.good;
   assign distance_in = update ? dist_new : distance_ff;
   assign lamp_in     = update ? lamp_new : lamp_ff;

   // Hold last good result
   always_ff @(posedge clock) begin
      if (reset) begin
         distance_ff <= '0;
         lamp_ff     <= '0;
      end else begin
         distance_ff <= distance_in;
         lamp_ff     <= lamp_in;
      end
   end

endmodule

FILE: src/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger: one request beat per tick, one response beat per request.
// The response to a request is valid in the cycle after the request is accepted.
// Throughput: one beat per cycle; the output register lets the next request in as a
// response drains, so the only stall is a full output register with rsp.ready low.
// Reset is synchronous and active high: phase idle, count, distance and lamps cleared,
// registers back to their defaults, no response pending.
`include "ultrasonic_echo_ranger_assert.svh"

module ultrasonic_echo_ranger (
   input  logic                            clock,
   input  logic                            reset,
   uer_req_if.sink                         req,
   uer_rsp_if.source                       rsp,
   input  logic                            csr_we,
   input  logic [uer_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [uer_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   uer_pkg::cfg_type              cfg;
   uer_pkg::evt_type              evt;
   logic [uer_pkg::DIST_W-1:0]    distance_in;
   uer_pkg::lamp_type             lamp_in;
   logic                          accept;
   logic                          rsp_valid_ff, rsp_valid_in;
   uer_pkg::evt_type              evt_ff;
   logic [uer_pkg::DIST_W-1:0]    distance_ff;
   uer_pkg::lamp_type             lamp_ff;

   uer_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   uer_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .start_req  (req.start_req),
      .echo_level (req.echo_level),
      .cfg        (cfg),
      .evt        (evt)
   );

   uer_range u_range (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .evt         (evt),
      .cfg         (cfg),
      .distance_in (distance_in),
      .lamp_in     (lamp_in)
   );

   // Take a beat when the output register is empty or draining
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         evt_ff      <= evt;
         distance_ff <= distance_in;
         lamp_ff     <= lamp_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.trigger_level = evt_ff.trigger;
   assign rsp.busy_res      = evt_ff.busy;
   assign rsp.done_res      = evt_ff.done;
   assign rsp.status        = evt_ff.status;
   assign rsp.distance      = distance_ff;
   assign rsp.lamp_far      = lamp_ff.far_on;
   assign rsp.lamp_mid      = lamp_ff.mid_on;
   assign rsp.lamp_near     = lamp_ff.near_on;

   `UER_ASSERT_NEXT(a_accept_gives_beat, clock, reset, accept, rsp_valid_ff)
   `UER_ASSERT_SAME(a_done_not_busy, clock, reset, rsp_valid_ff && evt_ff.done, !evt_ff.busy)
   `UER_ASSERT_SAME(a_trigger_busy, clock, reset, rsp_valid_ff && evt_ff.trigger, evt_ff.busy)
   `UER_ASSERT_SAME(a_status_on_done, clock, reset,
      rsp_valid_ff && (evt_ff.status != uer_pkg::ST_OK), evt_ff.done)
   `UER_ASSERT_SAME(a_lamps_onehot0, clock, reset, rsp_valid_ff, $onehot0(lamp_ff))

endmodule
